// File: hdl/exponential_search_key_defines.svh
`ifndef EXPONENTIAL_SEARCH_KEY_DEFINES_SVH
`define EXPONENTIAL_SEARCH_KEY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ESK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ESK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ESK_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ESK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: hdl/esk_pkg.sv
`default_nettype none

package esk_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = ADDR_W + 2;
   localparam int CNT_W       = 11;
   localparam int KEY_W       = 32;
   localparam int ENTRY_IDX_W = 10;
   localparam int POS_W       = 10;
   localparam int EXT_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam logic OPC_WRITE  = 1'b0;
   localparam logic OPC_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      RD_ZERO  = 2'd0,
      RD_BOUND = 2'd1,
      RD_MID   = 2'd2
   } esk_rd_sel_type;

   typedef struct packed {
      logic           write;
      logic           load;
      logic           bound_init;
      logic           bound_dbl;
      logic           range_init;
      logic           range_lo;
      logic           range_hi;
      logic           mid_load;
      logic           res_set;
      logic           out_load;
      esk_rd_sel_type rd_sel;
   } esk_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic one_lt_n;
      logic dbl_lt_n;
      logic hit;
      logic probe_gt;
      logic range_ok;
      logic out_free;
   } esk_status_type;

endpackage

`default_nettype wire

// File: hdl/esk_if.sv
`default_nettype none

interface esk_req_if import esk_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [ENTRY_IDX_W-1:0]  entry_index;
   logic signed [KEY_W-1:0] key_value;

   modport source (output valid, output opcode, output entry_index, output key_value,
                   input ready);
   modport sink (input valid, input opcode, input entry_index, input key_value,
                 output ready);
endinterface

interface esk_rsp_if import esk_pkg::*;;
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);
endinterface

interface esk_csr_if import esk_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/esk_datapath.sv
`default_nettype none

module esk_datapath import esk_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire esk_cmd_type             cmd,
   output esk_status_type               status,
   input  wire logic [ENTRY_IDX_W-1:0]  req_entry_index,
   input  wire logic signed [KEY_W-1:0] req_key_value,
   input  wire logic                    csr_write,
   input  wire logic [CNT_W-1:0]        csr_data,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [POS_W-1:0]             rsp_position
);

   logic [KEY_W-1:0]        mem [TABLE_DEPTH];
   logic [KEY_W-1:0]        rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic [EXT_W-1:0]        wr_idx_ext;
   logic                    wr_ok;

   logic [CNT_W-1:0]        count_ff;
   logic [EXT_W-1:0]        count_ext;
   logic [EXT_W-1:0]        n_wide;
   logic [IDX_W-1:0]        n_ff, n_in, n_m1;
   logic signed [KEY_W-1:0] key_ff, key_in;

   logic [IDX_W-1:0]        bound_ff, bound_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        mid_ff, mid_in, mid_calc;
   logic [EXT_W-1:0]        mid_ext;

   logic                    res_found_ff, res_found_in;
   logic [POS_W-1:0]        res_pos_ff, res_pos_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_found_ff, out_found_in;
   logic [POS_W-1:0]        out_pos_ff, out_pos_in;

   assign wr_idx_ext = EXT_W'(req_entry_index);
   assign wr_ok      = wr_idx_ext < EXT_W'(TABLE_DEPTH);

   assign count_ext = EXT_W'(count_ff);
   assign n_wide    = (count_ext > EXT_W'(TABLE_DEPTH)) ? EXT_W'(TABLE_DEPTH) : count_ext;
   assign n_m1      = n_ff - IDX_W'(1);
   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_ext   = EXT_W'(mid_ff);

   always_comb begin
      n_in   = cmd.load ? n_wide[IDX_W-1:0] : n_ff;
      key_in = cmd.load ? req_key_value : key_ff;

      if (cmd.bound_init) begin
         bound_in = IDX_W'(1);
      end else if (cmd.bound_dbl) begin
         bound_in = bound_ff << 1;
      end else begin
         bound_in = bound_ff;
      end

      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.range_init) begin
         lo_in = bound_in >> 1;
         hi_in = (bound_in < n_m1) ? bound_in : n_m1;
      end else if (cmd.range_lo) begin
         lo_in = mid_ff + IDX_W'(1);
      end else if (cmd.range_hi) begin
         hi_in = mid_ff - IDX_W'(1);
      end

      if (cmd.load) begin
         mid_in = '0;
      end else if (cmd.mid_load) begin
         mid_in = mid_calc;
      end else begin
         mid_in = mid_ff;
      end

      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      if (cmd.load) begin
         res_found_in = 1'b0;
         res_pos_in   = '0;
      end else if (cmd.res_set) begin
         res_found_in = 1'b1;
         res_pos_in   = mid_ext[POS_W-1:0];
      end

      out_found_in = cmd.out_load ? res_found_ff : out_found_ff;
      out_pos_in   = cmd.out_load ? res_pos_ff : out_pos_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      unique case (cmd.rd_sel)
         RD_ZERO:  rd_addr = '0;
         RD_BOUND: rd_addr = bound_in[ADDR_W-1:0];
         RD_MID:   rd_addr = mid_calc[ADDR_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_idx_ext[ADDR_W-1:0]] <= req_key_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      key_ff       <= key_in;
      bound_ff     <= bound_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_data;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.one_lt_n   = n_ff > IDX_W'(1);
   assign status.dbl_lt_n   = (bound_ff << 1) < n_ff;
   assign status.hit        = (rd_data_ff == key_ff);
   assign status.probe_gt   = $signed(rd_data_ff) > key_ff;
   assign status.range_ok   = $signed(lo_ff) <= $signed(hi_ff);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_position = out_pos_ff;

endmodule

`default_nettype wire

// File: hdl/esk_ctrl.sv
`default_nettype none

module esk_ctrl import esk_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_opcode,
   input  wire esk_status_type status,
   output logic                req_ready,
   output esk_cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CHK0 = 6'b000010,
      S_GROW = 6'b000100,
      S_BMID = 6'b001000,
      S_BCMP = 6'b010000,
      S_DONE = 6'b100000
   } esk_state_type;

   esk_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_ZERO;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OPC_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = status.count_zero ? S_DONE : S_CHK0;
               end
            end
         end
         S_CHK0: begin
            if (status.hit) begin
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.bound_init = 1'b1;
               if (status.one_lt_n) begin
                  cmd.rd_sel = RD_BOUND;
                  state_in   = S_GROW;
               end else begin
                  cmd.range_init = 1'b1;
                  state_in       = S_BMID;
               end
            end
         end
         S_GROW: begin
            if (status.probe_gt) begin
               cmd.range_init = 1'b1;
               state_in       = S_BMID;
            end else begin
               cmd.bound_dbl = 1'b1;
               if (status.dbl_lt_n) begin
                  cmd.rd_sel = RD_BOUND;
               end else begin
                  cmd.range_init = 1'b1;
                  state_in       = S_BMID;
               end
            end
         end
         S_BMID: begin
            if (status.range_ok) begin
               cmd.mid_load = 1'b1;
               cmd.rd_sel   = RD_MID;
               state_in     = S_BCMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BCMP: begin
            if (status.hit) begin
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end else begin
               if (status.probe_gt) begin
                  cmd.range_hi = 1'b1;
               end else begin
                  cmd.range_lo = 1'b1;
               end
               state_in = S_BMID;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/exponential_search_key.sv
// Channel   Dir  Item contents
// req_bus   in   opcode, entry_index, key_value
// rsp_bus   out  found, position (one per search item)
// csr_bus   in   data (entry count)
//
// A write item is handled in the idle state, which keeps the input ready for the next item.
// A search item holds the input until its result is loaded: a probe of entry 0, then
// bound probes that double the bound, then binary probes in the range up to it; a zero
// entry count skips the probes. Each probe is one read of the single key memory port.
// Reset is synchronous and clears the entry count and the control state, not the key
// memory. A stalled result stays in the output register and the next search waits.
`default_nettype none
`include "exponential_search_key_defines.svh"

module exponential_search_key import esk_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   esk_req_if.sink    req_bus,
   esk_rsp_if.source  rsp_bus,
   esk_csr_if.sink    csr_bus
);

   esk_cmd_type    cmd;
   esk_status_type status;

   assign csr_bus.ready = 1'b1;

   esk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .status     (status),
      .req_ready  (req_bus.ready),
      .cmd        (cmd)
   );

   esk_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_bus.entry_index),
      .req_key_value   (req_bus.key_value),
      .csr_write       (csr_bus.valid),
      .csr_data        (csr_bus.data),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_found       (rsp_bus.found),
      .rsp_position    (rsp_bus.position)
   );

   `ESK_ASSERT_NEXT(a_search_busy, clock, reset, req_bus.valid && req_bus.ready && (req_bus.opcode == OPC_SEARCH), !req_bus.ready, "search item did not block the input")
   `ESK_ASSERT_SAME(a_result_after_search, clock, reset, $rose(rsp_bus.valid), $past(!req_bus.ready), "result appeared without a search in progress")
   `ESK_ASSERT_SAME(a_miss_position, clock, reset, rsp_bus.valid && !rsp_bus.found, rsp_bus.position == '0, "position not zero on a miss")

endmodule

`default_nettype wire
